// ===== rtl/core/interval_overlap_peak_finder_defines.svh =====
// ----------------------------------------------------------------------------
// Interval overlap peak finder: assertion macros
// Shared concurrent assertion helpers for the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_OVERLAP_PEAK_FINDER_DEFINES_SVH
`define INTERVAL_OVERLAP_PEAK_FINDER_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define IOPF_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion on the block clock and reset.
`define IOPF_ASSERT(lbl, prop, msg) `IOPF_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/iopf_pkg.sv =====
// ----------------------------------------------------------------------------
// Interval overlap peak finder package
// Shared types and fixed constants of the peak finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iopf_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned YearW  = 16;
  localparam int unsigned CountW = 16;

  // Reset value of the window base year.
  localparam logic [YearW-1:0] BaseYearRst = 16'd1900;

  // Saturation limit of the reject tally and the reported count.
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_LO   = 6'b000100,
    S_HI   = 6'b001000,
    S_SCAN = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  // Control from the sequencer to the scan accumulator.
  typedef struct packed {
    logic start;
    logic valid;
  } scan_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/iopf_if.sv =====
// ----------------------------------------------------------------------------
// Interval overlap peak finder channels
// Valid/ready interfaces for intervals, results and the base year write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Interval input channel.
interface iopf_in_if;
  logic                             valid;
  logic                             ready;
  logic [iopf_pkg::YearW-1:0]       birth_year;
  logic [iopf_pkg::YearW-1:0]       death_year;
  logic                             last_interval;

  modport source (output valid, output birth_year, output death_year,
                  output last_interval, input ready);
  modport sink   (input valid, input birth_year, input death_year,
                  input last_interval, output ready);
endinterface

// Result output channel.
interface iopf_out_if;
  logic                             valid;
  logic                             ready;
  logic [iopf_pkg::YearW-1:0]       peak_year;
  logic [iopf_pkg::CountW-1:0]      peak_count;
  logic                             found;
  logic [iopf_pkg::CountW-1:0]      rejected_count;

  modport source (output valid, output peak_year, output peak_count,
                  output found, output rejected_count, input ready);
  modport sink   (input valid, input peak_year, input peak_count,
                  input found, input rejected_count, output ready);
endinterface

// Base year write channel.
interface iopf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [iopf_pkg::YearW-1:0]       data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/iopf_scan_acc.sv =====
// ----------------------------------------------------------------------------
// Interval overlap peak finder scan accumulator
// Running prefix sum over the difference entries with peak tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iopf_scan_acc #(
  parameter int unsigned YEARS      = 128,
  parameter int unsigned MAX_PEOPLE = 65535
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire iopf_pkg::scan_ctl_t                ctl_i,
  input  wire  [$clog2(YEARS+1)-1:0]              slot_i,
  input  wire  signed [$clog2(MAX_PEOPLE+1):0]    delta_i,
  output logic                                    found_o,
  output logic [$clog2(MAX_PEOPLE+1)-1:0]         best_o,
  output logic [$clog2(YEARS+1)-1:0]              slot_o
);

  localparam int unsigned AddrW  = $clog2(YEARS + 1);
  localparam int unsigned CntW   = $clog2(MAX_PEOPLE + 1);
  localparam int unsigned EntryW = CntW + 1;
  localparam int unsigned RunW   = EntryW + $clog2(YEARS);
  localparam logic signed [RunW-1:0] MaxRun = RunW'(MAX_PEOPLE);

  logic signed [RunW-1:0] run_q, run_d;
  logic [CntW-1:0]        best_q;
  logic [AddrW-1:0]       slot_q;
  logic                   found_q;
  logic [CntW-1:0]        clamp_c;
  logic                   better;

  // Next prefix sum and its count clamped to zero .. MAX_PEOPLE.
  always_comb begin
    run_d = run_q + RunW'(delta_i);
    priority if (run_d < 0) begin
      clamp_c = '0;
    end else if (run_d > MaxRun) begin
      clamp_c = CntW'(MAX_PEOPLE);
    end else begin
      clamp_c = run_d[CntW-1:0];
    end
    better = clamp_c > best_q;
  end

  // Found flag: cleared at the start of a scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.start) begin
      found_q <= 1'b0;
    end else if (ctl_i.valid && better) begin
      found_q <= 1'b1;
    end
  end

  // Sum, best count and the earliest slot that reached it.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      run_q  <= '0;
      best_q <= '0;
      slot_q <= '0;
    end else if (ctl_i.valid) begin
      run_q <= run_d;
      if (better) begin
        best_q <= clamp_c;
        slot_q <= slot_i;
      end
    end
  end

  assign found_o = found_q;
  assign best_o  = best_q;
  assign slot_o  = slot_q;

endmodule

`default_nettype wire

// ===== rtl/core/interval_overlap_peak_finder.sv =====
// ----------------------------------------------------------------------------
// Interval overlap peak finder
// Intervals go through the difference store as a read-modify-write of the
// start slot, then of the end slot; the next interval is taken during the
// end slot update. A set's result follows its last interval's two updates,
// a scan read of every slot and the result load (no updates if rejected).
// After reset the store is cleared before intervals are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "interval_overlap_peak_finder_defines.svh"

module interval_overlap_peak_finder #(
  parameter int unsigned YEARS      = 128,
  parameter int unsigned MAX_PEOPLE = 65535
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  iopf_in_if.sink    in_i,
  iopf_out_if.source out_o,
  iopf_cfg_if.sink   cfg_i
);

  localparam int unsigned Depth  = YEARS + 1;
  localparam int unsigned AddrW  = $clog2(YEARS + 1);
  localparam int unsigned CntW   = $clog2(MAX_PEOPLE + 1);
  localparam int unsigned EntryW = CntW + 1;
  localparam int unsigned WideW  = (CntW > 16) ? CntW : 16;
  localparam logic [AddrW-1:0] LastSlot = AddrW'(YEARS);
  localparam logic signed [EntryW:0] MaxEnt = (EntryW + 1)'(MAX_PEOPLE);

  // Saturating +1 / -1 update of one difference entry.
  function automatic logic signed [EntryW-1:0] sat_step(
    input logic signed [EntryW-1:0] v,
    input logic                     up
  );
    logic signed [EntryW:0] s;
    s = up ? ((EntryW + 1)'(v) + (EntryW + 1)'(1)) : ((EntryW + 1)'(v) - (EntryW + 1)'(1));
    if (s > MaxEnt) begin
      s = MaxEnt;
    end else if (s < -MaxEnt) begin
      s = -MaxEnt;
    end
    return s[EntryW-1:0];
  endfunction

  iopf_pkg::state_e state_q, state_d;

  logic [iopf_pkg::YearW-1:0]  base_q;
  logic [iopf_pkg::CountW-1:0] tally_q, tally_d;
  logic [AddrW-1:0]            lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d;
  logic                        last_q, last_d, fwd_q, fwd_d;
  logic signed [EntryW-1:0]    fwd_val_q, fwd_val_d;
  logic                        scan_vld_q, scan_vld_d;
  logic [AddrW-1:0]            scan_slot_q, scan_slot_d;

  // Difference store and its port signals.
  logic signed [EntryW-1:0]    mem_q [Depth];
  logic signed [EntryW-1:0]    rdata_q;
  logic                        mem_we, mem_re;
  logic [AddrW-1:0]            mem_waddr, mem_raddr;
  logic signed [EntryW-1:0]    mem_wdata;

  // Output register.
  logic                        out_valid_q;
  logic [iopf_pkg::YearW-1:0]  out_year_q;
  logic [iopf_pkg::CountW-1:0] out_count_q, out_rej_q;
  logic                        out_found_q;

  logic                        in_ready, in_fire, reject, tally_inc, fin_load;
  logic [16:0]                 last_year;
  logic [AddrW-1:0]            lo_c, hi_c;
  logic signed [EntryW-1:0]    lo_cur, hi_new;

  iopf_pkg::scan_ctl_t         scan_ctl;
  logic                        acc_found;
  logic [CntW-1:0]             acc_best;
  logic [AddrW-1:0]            acc_slot;
  logic [WideW-1:0]            best_wide;
  logic [iopf_pkg::CountW-1:0] count_c;
  logic [iopf_pkg::YearW-1:0]  year_c;

  // Window check and slot addresses of the offered interval.
  always_comb begin
    last_year = {1'b0, base_q} + 17'(YEARS - 1);
    reject    = (in_i.birth_year < base_q) || (in_i.death_year < in_i.birth_year) ||
                ({1'b0, in_i.death_year} > last_year);
    lo_c      = AddrW'(in_i.birth_year - base_q);
    hi_c      = AddrW'(in_i.death_year - base_q) + AddrW'(1);
  end

  // Intervals are taken while idle and during the end slot update of a
  // non-final interval.
  assign in_ready = (state_q == iopf_pkg::S_IDLE) ||
                    ((state_q == iopf_pkg::S_HI) && !last_q);
  assign in_fire  = in_i.valid && in_ready;
  assign lo_cur   = fwd_q ? fwd_val_q : rdata_q;
  assign hi_new   = sat_step(rdata_q, 1'b0);

  // Result fields from the accumulator.
  always_comb begin
    best_wide = WideW'(acc_best);
    count_c   = (best_wide > WideW'(iopf_pkg::CountMax)) ? iopf_pkg::CountMax
                                                          : best_wide[15:0];
    year_c    = acc_found ? (base_q + 16'(acc_slot)) : (base_q - 16'd1);
  end

  assign fin_load = (state_q == iopf_pkg::S_FIN) && (!out_valid_q || out_o.ready);

  // Sequencer: store clear, interval updates, scan and result hand-off.
  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    last_d      = last_q;
    fwd_d       = 1'b0;
    fwd_val_d   = fwd_val_q;
    ptr_d       = ptr_q;
    scan_vld_d  = 1'b0;
    scan_slot_d = scan_slot_q;
    tally_inc   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    unique case (state_q)
      iopf_pkg::S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        ptr_d     = ptr_q + AddrW'(1);
        if (ptr_q == LastSlot) begin
          ptr_d   = '0;
          state_d = iopf_pkg::S_IDLE;
        end
      end
      iopf_pkg::S_IDLE: begin
        if (in_fire) begin
          if (reject) begin
            tally_inc = 1'b1;
            if (in_i.last_interval) begin
              state_d = iopf_pkg::S_SCAN;
            end
          end else begin
            mem_re    = 1'b1;
            mem_raddr = lo_c;
            lo_d      = lo_c;
            hi_d      = hi_c;
            last_d    = in_i.last_interval;
            state_d   = iopf_pkg::S_LO;
          end
        end
      end
      iopf_pkg::S_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q;
        mem_wdata = sat_step(lo_cur, 1'b1);
        mem_re    = 1'b1;
        mem_raddr = hi_q;
        state_d   = iopf_pkg::S_HI;
      end
      iopf_pkg::S_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_q;
        mem_wdata = hi_new;
        if (last_q) begin
          state_d = iopf_pkg::S_SCAN;
        end else begin
          state_d = iopf_pkg::S_IDLE;
          if (in_fire) begin
            if (reject) begin
              tally_inc = 1'b1;
              if (in_i.last_interval) begin
                state_d = iopf_pkg::S_SCAN;
              end
            end else begin
              // The new start slot may be the end slot written right now.
              mem_re    = 1'b1;
              mem_raddr = lo_c;
              lo_d      = lo_c;
              hi_d      = hi_c;
              last_d    = in_i.last_interval;
              fwd_d     = (lo_c == hi_q);
              fwd_val_d = hi_new;
              state_d   = iopf_pkg::S_LO;
            end
          end
        end
      end
      iopf_pkg::S_SCAN: begin
        mem_re      = 1'b1;
        mem_raddr   = ptr_q;
        scan_vld_d  = 1'b1;
        scan_slot_d = ptr_q;
        ptr_d       = ptr_q + AddrW'(1);
        if (ptr_q == LastSlot) begin
          ptr_d   = '0;
          state_d = iopf_pkg::S_FIN;
        end
        // Clear each entry once its value has been read.
        if (scan_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = scan_slot_q;
        end
      end
      iopf_pkg::S_FIN: begin
        if (scan_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = scan_slot_q;
        end
        if (fin_load) begin
          state_d = iopf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = iopf_pkg::S_CLR;
        ptr_d   = '0;
      end
    endcase
  end

  // Reject tally, saturating, cleared when a result is taken over.
  always_comb begin
    tally_d = tally_q;
    if (fin_load) begin
      tally_d = '0;
    end else if (tally_inc && (tally_q != iopf_pkg::CountMax)) begin
      tally_d = tally_q + 16'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= iopf_pkg::S_CLR;
      ptr_q      <= '0;
      tally_q    <= '0;
      fwd_q      <= 1'b0;
      scan_vld_q <= 1'b0;
      base_q     <= iopf_pkg::BaseYearRst;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      tally_q    <= tally_d;
      fwd_q      <= fwd_d;
      scan_vld_q <= scan_vld_d;
      if (cfg_i.valid) begin
        base_q <= cfg_i.data;
      end
    end
  end

  // Interval payload registers.
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    last_q      <= last_d;
    fwd_val_q   <= fwd_val_d;
    scan_slot_q <= scan_slot_d;
  end

  // Difference store, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Prefix sum over the slots inside the window.
  always_comb begin
    scan_ctl.start = (state_d == iopf_pkg::S_SCAN) && (state_q != iopf_pkg::S_SCAN);
    scan_ctl.valid = scan_vld_q && (scan_slot_q != LastSlot);
  end

  iopf_scan_acc #(
    .YEARS      (YEARS),
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .slot_i  (scan_slot_q),
    .delta_i (rdata_q),
    .found_o (acc_found),
    .best_o  (acc_best),
    .slot_o  (acc_slot)
  );

  // Output register: holds a result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_year_q  <= year_c;
      out_count_q <= count_c;
      out_found_q <= acc_found;
      out_rej_q   <= tally_q;
    end
  end

  assign in_i.ready           = in_ready;
  assign cfg_i.ready          = 1'b1;
  assign out_o.valid          = out_valid_q;
  assign out_o.peak_year      = out_year_q;
  assign out_o.peak_count     = out_count_q;
  assign out_o.found          = out_found_q;
  assign out_o.rejected_count = out_rej_q;

  // Checks on forwarding, hazards, tally clearing, result hold and the peak bound.
  `IOPF_ASSERT(a_fwd_addr, fwd_q |-> (lo_q == $past(hi_q)), "forwarding without address match")
  `IOPF_ASSERT(a_hazard_fwd, (mem_we && mem_re && (mem_waddr == mem_raddr)) |=> fwd_q,
               "same-entry read and write without forwarding")
  `IOPF_ASSERT(a_tally_clr, fin_load |=> (tally_q == '0), "reject tally not cleared")
  `IOPF_ASSERT(a_best_bound, acc_best <= CntW'(MAX_PEOPLE), "peak count above limit")
  `IOPF_ASSERT(a_out_hold, (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_year_q)),
               "pending result lost")

endmodule

`default_nettype wire

// ===== tb/sv/tb_interval_overlap_peak_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval overlap peak finder testbench
// Drives sets of year intervals and base year writes into the block. A
// difference-store predictor in the bench computes each set's peak year,
// count, found flag and reject tally; each result is checked against it,
// or against the table entry for typed directed rows. A directed table
// comes first, then random sets at several base years and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_interval_overlap_peak_finder;

  localparam int Years         = 128;
  localparam int MaxPeople     = 65535;
  localparam int DrainCycles   = 2 * (Years + 4);
  localparam int WatchdogLimit = 4000;
  localparam int ReportLimit   = 10;
  localparam int ItemsPerPhase = 84;
  localparam int NumPhases     = 6;
  localparam int RandomBase    = 0;
  localparam int DirRows       = 22;

  // One result transaction, field by field.
  typedef struct packed {
    logic [iopf_pkg::YearW-1:0]  year;
    logic [iopf_pkg::CountW-1:0] count;
    logic                        found;
    logic [iopf_pkg::CountW-1:0] rejected;
  } peak_result_t;

  // One directed interval; want is only used where typed is set.
  typedef struct packed {
    logic [iopf_pkg::YearW-1:0] birth;
    logic [iopf_pkg::YearW-1:0] death;
    logic                       last;
    logic                       typed;
    peak_result_t               want;
  } interval_row_t;

  localparam interval_row_t DirTable [DirRows] = '{
    // Single years at both ends of the default window, and the full window.
    '{16'd1900, 16'd1900, 1'b1, 1'b1, '{16'd1900, 16'd1, 1'b1, 16'd0}},
    '{16'd2027, 16'd2027, 1'b1, 1'b1, '{16'd2027, 16'd1, 1'b1, 16'd0}},
    '{16'd1900, 16'd2027, 1'b1, 1'b1, '{16'd1900, 16'd1, 1'b1, 16'd0}},
    // Start below the window, reversed pair, end past the window.
    '{16'd1899, 16'd1950, 1'b1, 1'b1, '{16'd1899, 16'd0, 1'b0, 16'd1}},
    '{16'd1950, 16'd1949, 1'b1, 1'b1, '{16'd1899, 16'd0, 1'b0, 16'd1}},
    '{16'd1900, 16'd2028, 1'b1, 1'b1, '{16'd1899, 16'd0, 1'b0, 16'd1}},
    // Field extremes, all rejected, so the set comes back empty.
    '{16'd0,     16'd0,     1'b0, 1'b0, '0},
    '{16'd65535, 16'd65535, 1'b0, 1'b0, '0},
    '{16'd65535, 16'd0,     1'b0, 1'b0, '0},
    '{16'd0,     16'd65535, 1'b1, 1'b1, '{16'd1899, 16'd0, 1'b0, 16'd4}},
    // Tie between two peaks: the earlier year must win.
    '{16'd1910, 16'd1920, 1'b0, 1'b0, '0},
    '{16'd1915, 16'd1930, 1'b0, 1'b0, '0},
    '{16'd1918, 16'd1925, 1'b0, 1'b0, '0},
    '{16'd1900, 16'd1917, 1'b1, 1'b0, '0},
    // Adjacent intervals never overlap.
    '{16'd1950, 16'd1960, 1'b0, 1'b0, '0},
    '{16'd1961, 16'd1970, 1'b1, 1'b0, '0},
    // A reject mixed with an accepted interval.
    '{16'd1800, 16'd1850, 1'b0, 1'b0, '0},
    '{16'd1905, 16'd1906, 1'b1, 1'b0, '0},
    // Stacked identical intervals.
    '{16'd2000, 16'd2000, 1'b0, 1'b0, '0},
    '{16'd2000, 16'd2000, 1'b0, 1'b0, '0},
    '{16'd2000, 16'd2000, 1'b0, 1'b0, '0},
    '{16'd2000, 16'd2000, 1'b1, 1'b0, '0}
  };

  // Per phase: base year, sender idle and receiver stall percentages.
  localparam int PhaseBase  [NumPhases] = '{1, 65535, 65500, RandomBase, 1900, RandomBase};
  localparam int PhaseIdle  [NumPhases] = '{0, 61, 0, 19, 61, 0};
  localparam int PhaseStall [NumPhases] = '{0, 0, 61, 19, 0, 61};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  iopf_in_if  in_if ();
  iopf_out_if out_if ();
  iopf_cfg_if cfg_if ();

  interval_overlap_peak_finder u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Predictor state: base year, difference store and reject tally.
  int unsigned                 base_year_q  = iopf_pkg::BaseYearRst;
  int                          slot_delta [Years+1];
  logic [iopf_pkg::CountW-1:0] reject_tally = '0;
  peak_result_t                expected_peaks [$];

  // Stimulus side bookkeeping.
  int unsigned  window_base = iopf_pkg::BaseYearRst;
  int           idle_pct    = 0;
  int           stall_pct   = 0;
  int           items_sent  = 0;
  logic         row_typed;
  peak_result_t row_want;

  int mismatches  = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  // Applies one interval to the predictor; on the last of a set it scans the
  // store, fills in the result and clears the store and the tally.
  function automatic logic tally_interval(input logic [iopf_pkg::YearW-1:0] birth,
                                          input logic [iopf_pkg::YearW-1:0] death,
                                          input logic last, output peak_result_t res);
    int unsigned last_year, lo, hi, top_slot;
    int          run, best, level;
    logic        hit;
    res       = '0;
    last_year = base_year_q + Years - 1;
    if (birth < base_year_q || death < birth || death > last_year) begin
      if (reject_tally != iopf_pkg::CountMax) reject_tally++;
    end else begin
      lo = birth - base_year_q;
      hi = death - base_year_q + 1;
      if (slot_delta[lo] < MaxPeople) slot_delta[lo]++;
      if (slot_delta[hi] > -MaxPeople) slot_delta[hi]--;
    end
    if (!last) return 1'b0;

    // Running count, clamped, strictly greater keeps the earliest year.
    run      = 0;
    best     = 0;
    top_slot = 0;
    hit      = 1'b0;
    for (int i = 0; i < Years; i++) begin
      run  += slot_delta[i];
      level = (run < 0) ? 0 : ((run > MaxPeople) ? MaxPeople : run);
      if (level > best) begin
        best     = level;
        top_slot = i;
        hit      = 1'b1;
      end
    end
    res.found    = hit;
    res.year     = hit ? iopf_pkg::YearW'(base_year_q + top_slot)
                       : iopf_pkg::YearW'(base_year_q - 1);
    res.count    = (best > 65535) ? iopf_pkg::CountMax : iopf_pkg::CountW'(best);
    res.rejected = reject_tally;
    slot_delta   = '{default: 0};
    reject_tally = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("mismatch on %s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Receiver: ready drawn every cycle against the stall percentage.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Monitor: checks results, feeds the predictor, tracks the base year and
  // runs the watchdog on cycles without any transaction.
  always @(posedge clk) begin
    peak_result_t res;
    logic         produced;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_peaks.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("unexpected result: peak_year %0d peak_count %0d",
                     out_if.peak_year, out_if.peak_count);
        end else begin
          res = expected_peaks.pop_front();
          check_field("peak_year", res.year, out_if.peak_year);
          check_field("peak_count", res.count, out_if.peak_count);
          check_field("found", 16'(res.found), 16'(out_if.found));
          check_field("rejected_count", res.rejected, out_if.rejected_count);
        end
      end
      if (in_if.valid && in_if.ready) begin
        produced = tally_interval(in_if.birth_year, in_if.death_year,
                                  in_if.last_interval, res);
        if (produced) expected_peaks.push_back(row_typed ? row_want : res);
      end
      if (cfg_if.valid && cfg_if.ready) base_year_q = cfg_if.data;

      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Sends one interval; valid stays high when the next one follows directly.
  task automatic send_interval(input logic [iopf_pkg::YearW-1:0] birth,
                               input logic [iopf_pkg::YearW-1:0] death,
                               input logic last, input logic typed, input peak_result_t want);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.birth_year    <= birth;
    in_if.death_year    <= death;
    in_if.last_interval <= last;
    row_typed           <= typed;
    row_want            <= want;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Holds the sender until every result has arrived and the scan has settled.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_base_year(input logic [iopf_pkg::YearW-1:0] year);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= year;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    window_base = year;
  endtask

  // One random set: mostly in-window intervals, some noise and reversed pairs.
  task automatic send_random_set();
    int                         len, span, lo, hi;
    logic [iopf_pkg::YearW-1:0] birth, death;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    span = (window_base + Years - 1 > 65535) ? 65535 - window_base : Years - 1;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          birth = iopf_pkg::YearW'($urandom);
          death = iopf_pkg::YearW'($urandom);
        end
        2: begin
          birth = iopf_pkg::YearW'(window_base + $urandom_range(0, span));
          death = birth - iopf_pkg::YearW'($urandom_range(1, 4));
        end
        3: begin
          birth = iopf_pkg::YearW'(window_base);
          death = iopf_pkg::YearW'(window_base + span);
        end
        default: begin
          lo    = $urandom_range(0, span);
          hi    = ($urandom_range(0, 1) == 0) ? $urandom_range(lo, span)
                                               : $urandom_range(lo, (lo + 7 > span) ? span : lo + 7);
          birth = iopf_pkg::YearW'(window_base + lo);
          death = iopf_pkg::YearW'(window_base + hi);
        end
      endcase
      send_interval(birth, death, k == len - 1, 1'b0, '0);
    end
  endtask

  // Main sequence: reset, directed table, then random phases.
  initial begin
    int phase_start;
    in_if.valid         = 1'b0;
    in_if.birth_year    = '0;
    in_if.death_year    = '0;
    in_if.last_interval = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = iopf_pkg::BaseYearRst;
    out_if.ready        = 1'b0;
    row_typed           = 1'b0;
    row_want            = '0;
    slot_delta          = '{default: 0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DirRows; r++)
      send_interval(DirTable[r].birth, DirTable[r].death, DirTable[r].last,
                    DirTable[r].typed, DirTable[r].want);

    for (int p = 0; p < NumPhases; p++) begin
      set_base_year((PhaseBase[p] == RandomBase) ? iopf_pkg::YearW'($urandom_range(1, 65535))
                                                 : iopf_pkg::YearW'(PhaseBase[p]));
      idle_pct    = PhaseIdle[p];
      stall_pct   = PhaseStall[p];
      phase_start = items_sent;
      while (items_sent - phase_start < ItemsPerPhase) send_random_set();
    end

    drain_results();
    if (mismatches == 0 && expected_peaks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/iopf_pkg.sv
rtl/core/iopf_if.sv
rtl/core/iopf_scan_acc.sv
rtl/core/interval_overlap_peak_finder.sv
tb/sv/tb_interval_overlap_peak_finder.sv
